// ----- hw/rtl/cdll_pkg.sv -----
// cdll_pkg: operation and status codes, field widths and the slot command
// type shared by the circular doubly linked list block.
// No dependencies.
`default_nettype none

package cdll_pkg;

  // field widths of the input and result words
  localparam int OP_W   = 4;
  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_INS_FRONT = 4'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 4'd1;
  localparam logic [OP_W-1:0] OP_INS_AT    = 4'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 4'd3;
  localparam logic [OP_W-1:0] OP_DEL_BACK  = 4'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 4'd5;
  localparam logic [OP_W-1:0] OP_READ_FWD  = 4'd6;
  localparam logic [OP_W-1:0] OP_READ_BWD  = 4'd7;
  localparam logic [OP_W-1:0] OP_CLEAR     = 4'd8;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef logic signed [DATA_W-1:0] data_t;

  // command to the slot allocator
  typedef struct packed {
    logic take;
    logic free;
    logic wipe;
  } slot_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cdll_ifs.sv -----
// cdll_in_if / cdll_out_if: valid-ready channels for operation words and
// result words. Depends on cdll_pkg.
`default_nettype none

interface cdll_in_if;
  import cdll_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  data_t               value;
  logic [POS_W-1:0]    position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink   (input valid, input operation, input value, input position,
                  output ready);
endinterface

interface cdll_out_if;
  import cdll_pkg::*;

  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  data_t               read_value;
  logic                last;
  logic [LEN_W-1:0]    length;

  modport source (output valid, output status, output read_value, output last,
                  output length, input ready);
  modport sink   (input valid, input status, input read_value, input last,
                  input length, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/circular_doubly_linked_list_core.sv -----
// circular_doubly_linked_list_core: top level of the linked list block,
// joining the sequencer, the node pool memories and the slot allocator.
// Depends on cdll_pkg, cdll_ifs, cdll_alloc, cdll_store and cdll_ctrl.
//
//   channel   dir   handshake      word
//   in_port   in    valid/ready    operation, value, position
//   out_port  out   valid/ready    status, read_value, last, length
//
// One operation at a time; the walk follows one link per cycle through the
// registered read port of the node pool. Inserts walk, write the new node
// and relink its neighbours; deletes walk and unlink; reads walk, then stream.
// Errors, clear and a first insert answer directly. Reset is synchronous and
// leaves an empty list at once; the pool memories are not cleared.
// A stalled result word holds the sequencer in its emit step; a new word is
// taken as soon as the sequencer is idle, even while a result still waits.
`default_nettype none

module circular_doubly_linked_list_core #(
  parameter int CAPACITY = 16
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  cdll_in_if.sink      in_port,
  cdll_out_if.source   out_port
);
  import cdll_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);

  logic [IDX_W-1:0] rd_addr;
  logic             nx_we;
  logic [IDX_W-1:0] nx_wa;
  logic [IDX_W-1:0] nx_wd;
  logic             pv_we;
  logic [IDX_W-1:0] pv_wa;
  logic [IDX_W-1:0] pv_wd;
  logic             val_we;
  data_t            val_wd;
  logic [IDX_W-1:0] rd_next;
  logic [IDX_W-1:0] rd_prev;
  data_t            rd_val;
  slot_cmd_t        slot_cmd;
  logic [IDX_W-1:0] slot_idx;
  logic [IDX_W-1:0] free_idx;

  // slot allocator
  cdll_alloc #(.CAPACITY(CAPACITY)) u_alloc (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (slot_cmd),
    .idx      (slot_idx),
    .free_idx (free_idx)
  );

  // node pool
  cdll_store #(.CAPACITY(CAPACITY)) u_store (
    .clk       (clk),
    .rd_addr   (rd_addr),
    .nx_we     (nx_we),
    .nx_wa     (nx_wa),
    .nx_wd     (nx_wd),
    .pv_we     (pv_we),
    .pv_wa     (pv_wa),
    .pv_wd     (pv_wd),
    .val_we    (val_we),
    .val_wd    (val_wd),
    .rd_next_r (rd_next),
    .rd_prev_r (rd_prev),
    .rd_val_r  (rd_val)
  );

  // sequencer and result register
  cdll_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_port),
    .out_port (out_port),
    .rd_addr  (rd_addr),
    .nx_we    (nx_we),
    .nx_wa    (nx_wa),
    .nx_wd    (nx_wd),
    .pv_we    (pv_we),
    .pv_wa    (pv_wa),
    .pv_wd    (pv_wd),
    .val_we   (val_we),
    .val_wd   (val_wd),
    .rd_next  (rd_next),
    .rd_prev  (rd_prev),
    .rd_val   (rd_val),
    .slot_cmd (slot_cmd),
    .slot_idx (slot_idx),
    .free_idx (free_idx)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/cdll_alloc.sv -----
// cdll_alloc: slot-in-use bitmap and lowest-free-slot encoder.
// Depends on cdll_pkg.
`default_nettype none

module cdll_alloc #(
  parameter int CAPACITY = 16,
  localparam int IDX_W = $clog2(CAPACITY)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cdll_pkg::slot_cmd_t cmd,
  input  wire logic [IDX_W-1:0]  idx,
  output logic [IDX_W-1:0]       free_idx
);
  import cdll_pkg::*;

  logic [CAPACITY-1:0] used_r;
  logic [CAPACITY-1:0] used_nxt;

  // bitmap update
  always_comb begin
    used_nxt = used_r;
    if (cmd.wipe) begin
      used_nxt = '0;
    end else if (cmd.take) begin
      used_nxt[idx] = 1'b1;
    end else if (cmd.free) begin
      used_nxt[idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // lowest unused slot, top slot when none below is free
  always_comb begin
    free_idx = IDX_W'(CAPACITY - 1);
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cdll_store.sv -----
// cdll_store: node pool memories (value, next link, previous link), one
// shared read address with registered outputs and one write port per memory.
// Depends on cdll_pkg.
`default_nettype none

module cdll_store #(
  parameter int CAPACITY = 16,
  localparam int IDX_W = $clog2(CAPACITY)
) (
  input  wire logic              clk,
  input  wire logic [IDX_W-1:0]  rd_addr,
  input  wire logic              nx_we,
  input  wire logic [IDX_W-1:0]  nx_wa,
  input  wire logic [IDX_W-1:0]  nx_wd,
  input  wire logic              pv_we,
  input  wire logic [IDX_W-1:0]  pv_wa,
  input  wire logic [IDX_W-1:0]  pv_wd,
  input  wire logic              val_we,
  input  wire cdll_pkg::data_t   val_wd,
  output logic [IDX_W-1:0]       rd_next_r,
  output logic [IDX_W-1:0]       rd_prev_r,
  output cdll_pkg::data_t        rd_val_r
);
  import cdll_pkg::*;

  logic [IDX_W-1:0] next_mem [CAPACITY];
  logic [IDX_W-1:0] prev_mem [CAPACITY];
  data_t            val_mem  [CAPACITY];

  // value shares the next-link write address
  always_ff @(posedge clk) begin
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    if (val_we) begin
      val_mem[nx_wa] <= val_wd;
    end
    if (pv_we) begin
      prev_mem[pv_wa] <= pv_wd;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_next_r <= next_mem[rd_addr];
    rd_prev_r <= prev_mem[rd_addr];
    rd_val_r  <= val_mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cdll_ctrl.sv -----
// cdll_ctrl: operation sequencer (link walk, relink, read streaming), list
// head state and the result word register.
// Depends on cdll_pkg and cdll_ifs; drives cdll_store and cdll_alloc.
`default_nettype none

module cdll_ctrl #(
  parameter int CAPACITY = 16,
  localparam int IDX_W = $clog2(CAPACITY)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  cdll_in_if.sink                in_port,
  cdll_out_if.source             out_port,
  // node pool
  output logic [IDX_W-1:0]       rd_addr,
  output logic                   nx_we,
  output logic [IDX_W-1:0]       nx_wa,
  output logic [IDX_W-1:0]       nx_wd,
  output logic                   pv_we,
  output logic [IDX_W-1:0]       pv_wa,
  output logic [IDX_W-1:0]       pv_wd,
  output logic                   val_we,
  output cdll_pkg::data_t        val_wd,
  input  wire logic [IDX_W-1:0]  rd_next,
  input  wire logic [IDX_W-1:0]  rd_prev,
  input  wire cdll_pkg::data_t   rd_val,
  // slot allocator
  output cdll_pkg::slot_cmd_t    slot_cmd,
  output logic [IDX_W-1:0]       slot_idx,
  input  wire logic [IDX_W-1:0]  free_idx
);
  import cdll_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_LINK = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  data_t             val_r, val_nxt;
  logic [IDX_W-1:0]  node_r, node_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]  nx_r, nx_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic              as_tail_r, as_tail_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  data_t             out_value_r;
  logic              out_last_r;
  logic [LEN_W-1:0]  out_len_r;

  logic              in_acc;
  logic              out_free;
  logic              load;
  logic [STAT_W-1:0] ld_status;
  data_t             ld_value;
  logic              ld_last;
  logic              first_ins;
  logic              is_ins;
  logic              is_del;
  logic              is_full;
  logic              is_empty;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CNT_W+LEN_W-1:0] cnt_wide;

  assign in_port.ready = (state_r == S_IDLE);
  assign in_acc        = in_port.valid && in_port.ready;
  assign out_free      = !out_valid_r || out_port.ready;

  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign pos_ext  = CMP_W'(in_port.position);
  assign cnt_ext  = CMP_W'(count_r);
  assign cnt_wide = {{LEN_W{1'b0}}, count_r};

  assign is_ins = (op_r == OP_INS_FRONT) || (op_r == OP_INS_BACK) || (op_r == OP_INS_AT);
  assign is_del = (op_r == OP_DEL_FRONT) || (op_r == OP_DEL_BACK) || (op_r == OP_DEL_AT);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    val_nxt     = val_r;
    node_nxt    = node_r;
    cur_nxt     = cur_r;
    nx_nxt      = nx_r;
    rem_nxt     = rem_r;
    left_nxt    = left_r;
    as_tail_nxt = as_tail_r;
    status_nxt  = status_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    rd_addr     = cur_r;
    nx_we       = 1'b0;
    nx_wa       = node_r;
    nx_wd       = node_r;
    pv_we       = 1'b0;
    pv_wa       = node_r;
    pv_wd       = node_r;
    val_we      = 1'b0;
    val_wd      = val_r;
    slot_cmd    = '0;
    slot_idx    = node_r;
    load        = 1'b0;
    ld_status   = status_r;
    ld_value    = '0;
    ld_last     = 1'b1;
    first_ins   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        rd_addr = tail_r;
        if (in_acc) begin
          op_nxt      = in_port.operation;
          val_nxt     = in_port.value;
          cur_nxt     = tail_r;
          node_nxt    = free_idx;
          left_nxt    = count_r;
          as_tail_nxt = 1'b0;
          rem_nxt     = '0;
          status_nxt  = ST_OK;
          state_nxt   = S_RESP;
          unique case (in_port.operation)
            OP_INS_FRONT, OP_INS_BACK: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else if (is_empty) begin
                first_ins = 1'b1;
              end else begin
                as_tail_nxt = (in_port.operation == OP_INS_BACK);
                state_nxt   = S_WALK;
              end
            end
            OP_INS_AT: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
                status_nxt = ST_RANGE;
              end else if (is_empty) begin
                first_ins = 1'b1;
              end else begin
                // walk to the node before the position
                rem_nxt     = CNT_W'(pos_ext - CMP_W'(1));
                as_tail_nxt = (pos_ext == cnt_ext + CMP_W'(1));
                state_nxt   = S_WALK;
              end
            end
            OP_DEL_FRONT, OP_DEL_BACK: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                rem_nxt   = (in_port.operation == OP_DEL_FRONT) ? CNT_W'(1) : '0;
                state_nxt = S_WALK;
              end
            end
            OP_DEL_AT: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                status_nxt = ST_RANGE;
              end else begin
                rem_nxt   = CNT_W'(pos_ext);
                state_nxt = S_WALK;
              end
            end
            OP_READ_FWD, OP_READ_BWD: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                rem_nxt   = (in_port.operation == OP_READ_FWD) ? CNT_W'(1) : '0;
                state_nxt = S_WALK;
              end
            end
            OP_CLEAR: begin
              slot_cmd.wipe = 1'b1;
              count_nxt     = '0;
              tail_nxt      = '0;
            end
            default: begin
            end
          endcase

          // first node of an empty list links to itself
          if (first_ins) begin
            nx_we         = 1'b1;
            nx_wa         = free_idx;
            nx_wd         = free_idx;
            pv_we         = 1'b1;
            pv_wa         = free_idx;
            pv_wd         = free_idx;
            val_we        = 1'b1;
            val_wd        = in_port.value;
            slot_cmd.take = 1'b1;
            slot_idx      = free_idx;
            tail_nxt      = free_idx;
            count_nxt     = CNT_W'(1);
          end
        end
      end

      S_WALK: begin
        if (rem_r != '0) begin
          // follow one next link per cycle
          rd_addr = rd_next;
          cur_nxt = rd_next;
          rem_nxt = rem_r - CNT_W'(1);
        end else if (is_ins) begin
          // new node sits between cur and its successor
          nx_we     = 1'b1;
          nx_wa     = node_r;
          nx_wd     = rd_next;
          pv_we     = 1'b1;
          pv_wa     = node_r;
          pv_wd     = cur_r;
          val_we    = 1'b1;
          nx_nxt    = rd_next;
          state_nxt = S_LINK;
        end else if (is_del) begin
          // unlink cur from its neighbors
          nx_we         = 1'b1;
          nx_wa         = rd_prev;
          nx_wd         = rd_next;
          pv_we         = 1'b1;
          pv_wa         = rd_next;
          pv_wd         = rd_prev;
          slot_cmd.free = 1'b1;
          slot_idx      = cur_r;
          count_nxt     = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            tail_nxt = '0;
          end else if (cur_r == tail_r) begin
            tail_nxt = rd_prev;
          end
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_READ;
        end
      end

      S_LINK: begin
        nx_we         = 1'b1;
        nx_wa         = cur_r;
        nx_wd         = node_r;
        pv_we         = 1'b1;
        pv_wa         = nx_r;
        pv_wd         = node_r;
        slot_cmd.take = 1'b1;
        slot_idx      = node_r;
        count_nxt     = count_r + CNT_W'(1);
        if (as_tail_r) begin
          tail_nxt = node_r;
        end
        state_nxt = S_RESP;
      end

      S_READ: begin
        // one element per cycle while the result register drains
        if (out_free) begin
          load      = 1'b1;
          ld_status = ST_OK;
          ld_value  = rd_val;
          ld_last   = (left_r == CNT_W'(1));
          left_nxt  = left_r - CNT_W'(1);
          if (left_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            rd_addr = (op_r == OP_READ_FWD) ? rd_next : rd_prev;
            cur_nxt = rd_addr;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    node_r    <= node_nxt;
    cur_r     <= cur_nxt;
    nx_r      <= nx_nxt;
    rem_r     <= rem_nxt;
    left_r    <= left_nxt;
    as_tail_r <= as_tail_nxt;
    status_r  <= status_nxt;
  end

  // result word register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_port.ready;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= ld_status;
      out_value_r  <= ld_value;
      out_last_r   <= ld_last;
      out_len_r    <= cnt_wide[LEN_W-1:0];
    end
  end

  assign out_port.valid      = out_valid_r;
  assign out_port.status     = out_status_r;
  assign out_port.read_value = out_value_r;
  assign out_port.last       = out_last_r;
  assign out_port.length     = out_len_r;

endmodule

`default_nettype wire
